// File: rtl/opi_pkg.sv
// Shared types, constants and the quarter-wave sine table for the pose integrator.
package opi_pkg;

  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned POS_W      = 48;
  localparam int unsigned QTE        = 256;  // quarter-wave table steps; the table holds QTE + 1 entries
  localparam int unsigned PHASE_W    = ANGLE_BITS - 2;
  localparam int unsigned IDX_W      = $clog2(QTE + 1);
  localparam int unsigned TBL_W      = 15;
  localparam int unsigned TRIG_W     = TBL_W + 1;
  localparam int unsigned PROD_W     = DIST_W + TRIG_W;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned HORNER_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                 64'd42, 64'd20, 64'd6};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // One classified update travelling from front to back
  typedef struct packed {
    logic signed [DIST_W-1:0] dist_inc;
    logic [ANGLE_BITS-1:0]    heading;
    quad_e                    quad;
    logic [IDX_W-1:0]         idx;
  } op_t;

  typedef logic [TBL_W-1:0] sine_tbl_t [QTE+1];

  // Evaluated at elaboration only: Taylor series to x^13 in Q30, Horner form
  function automatic sine_tbl_t build_sine_table();
    sine_tbl_t       tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned q;
    for (int i = 0; i <= int'(QTE); i++) begin
      x  = (longint'(i) * HALF_PI_Q30 + QTE / 2) / QTE;
      x2 = (x * x) >> 30;
      r  = Q30_ONE;
      for (int k = 0; k < 6; k++) begin
        r = Q30_ONE - ((x2 * r) >> 30) / HORNER_DIV[k];
      end
      s = (x * r) >> 30;
      q = (s + (64'd1 << 14)) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tbl[i] = q[TBL_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_table();

endpackage

// File: rtl/opi_front.sv
// Front end: heading accumulation and quadrant / table index classification.
module opi_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [opi_pkg::DIST_W-1:0]   delta_dist_i,
  input  logic signed [opi_pkg::DIST_W-1:0]   delta_heading_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output opi_pkg::op_t                        op_o
);

  localparam int unsigned SCL_W = opi_pkg::PHASE_W + opi_pkg::IDX_W;

  logic [opi_pkg::ANGLE_BITS-1:0] heading_q, heading_d;
  logic [opi_pkg::PHASE_W-1:0]    phase;
  logic [SCL_W-1:0]               scaled;
  logic [opi_pkg::IDX_W-1:0]      idx_raw;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Heading wraps modulo one turn
  assign heading_d = heading_q
                   + opi_pkg::ANGLE_BITS'($signed(delta_heading_i));

  assign phase   = heading_d[opi_pkg::PHASE_W-1:0];
  assign scaled  = SCL_W'(phase) * SCL_W'(opi_pkg::QTE)
                 + SCL_W'(1 << (opi_pkg::PHASE_W - 1));
  assign idx_raw = scaled[SCL_W-1 -: opi_pkg::IDX_W];

  always_comb begin
    op_o.dist_inc = delta_dist_i;
    op_o.heading  = heading_d;
    op_o.quad     = opi_pkg::quad_e'(heading_d[opi_pkg::ANGLE_BITS-1 -: 2]);
    op_o.idx      = (idx_raw > opi_pkg::IDX_W'(opi_pkg::QTE))
                  ? opi_pkg::IDX_W'(opi_pkg::QTE) : idx_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
    end else if (push_o) begin
      heading_q <= heading_d;
    end
  end

endmodule

// File: rtl/opi_queue.sv
// Short FIFO of classified updates between front and back.
module opi_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  opi_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output opi_pkg::op_t op_o
);

  opi_pkg::op_t                 mem_q [opi_pkg::QDEPTH];
  logic [opi_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [opi_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == opi_pkg::QCNT_W'(opi_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/opi_back.sv
// Back end: table lookup, products and saturating position accumulation.
module opi_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  opi_pkg::op_t                          op_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [opi_pkg::POS_W-1:0]      pos_x_o,
  output logic signed [opi_pkg::POS_W-1:0]      pos_y_o,
  output logic [opi_pkg::ANGLE_BITS-1:0]        heading_o
);

  localparam int unsigned POS_W = opi_pkg::POS_W;

  // Lookup stage
  logic                                 s1_v_q;
  logic signed [opi_pkg::TRIG_W-1:0]    sn_q, cs_q, sn_d, cs_d;
  logic signed [opi_pkg::DIST_W-1:0]    s1_dist_q;
  logic [opi_pkg::ANGLE_BITS-1:0]       s1_head_q;
  // Product stage
  logic                                 s2_v_q;
  logic signed [opi_pkg::PROD_W-1:0]    px_q, py_q;
  logic [opi_pkg::ANGLE_BITS-1:0]       s2_head_q;
  // Result register, doubles as the pose state
  logic                                 out_v_q;
  logic signed [POS_W-1:0]              pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [opi_pkg::ANGLE_BITS-1:0]       head_q;

  logic signed [opi_pkg::TRIG_W-1:0]    sa, sb;
  logic signed [POS_W:0]                sum_x, sum_y;
  logic                                 out_rdy, s2_rdy, s1_rdy;

  assign out_rdy = !out_v_q || out_ready_i;
  assign s2_rdy  = !s2_v_q || out_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign pop_o   = q_valid_i && s1_rdy;

  assign sa = $signed({1'b0, opi_pkg::SINE_TBL[op_i.idx]});
  assign sb = $signed({1'b0,
                       opi_pkg::SINE_TBL[opi_pkg::IDX_W'(opi_pkg::QTE) - op_i.idx]});

  always_comb begin
    case (op_i.quad)
      opi_pkg::QUAD_0: begin sn_d = sa;  cs_d = sb;  end
      opi_pkg::QUAD_1: begin sn_d = sb;  cs_d = -sa; end
      opi_pkg::QUAD_2: begin sn_d = -sa; cs_d = -sb; end
      opi_pkg::QUAD_3: begin sn_d = -sb; cs_d = sa;  end
      default:         begin sn_d = sa;  cs_d = sb;  end
    endcase
  end

  // One guard bit, clamp when it disagrees with the sign
  assign sum_x = {pos_x_q[POS_W-1], pos_x_q} + (POS_W+1)'(px_q);
  assign sum_y = {pos_y_q[POS_W-1], pos_y_q} + (POS_W+1)'(py_q);

  always_comb begin
    pos_x_d = sum_x[POS_W-1:0];
    if (sum_x[POS_W] != sum_x[POS_W-1]) begin
      pos_x_d = {sum_x[POS_W], {(POS_W-1){!sum_x[POS_W]}}};
    end
    pos_y_d = sum_y[POS_W-1:0];
    if (sum_y[POS_W] != sum_y[POS_W-1]) begin
      pos_y_d = {sum_y[POS_W], {(POS_W-1){!sum_y[POS_W]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sn_q      <= sn_d;
      cs_q      <= cs_d;
      s1_dist_q <= op_i.dist_inc;
      s1_head_q <= op_i.heading;
    end
    if (s1_v_q && s2_rdy) begin
      px_q      <= s1_dist_q * cs_q;
      py_q      <= s1_dist_q * sn_q;
      s2_head_q <= s1_head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      head_q  <= '0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= q_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
        if (s2_v_q) begin
          pos_x_q <= pos_x_d;
          pos_y_q <= pos_y_d;
          head_q  <= s2_head_q;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign heading_o   = head_q;

  // Pose state changes only when a new result is loaded into the output register
  a_pose_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_rdy && s2_v_q) |=> $stable(pos_x_q) && $stable(pos_y_q))
    else $error("pose changed without a product being absorbed");

  // A stalled product stage keeps its products
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !out_rdy |=> s2_v_q && $stable(px_q) && $stable(py_q))
    else $error("product stage lost data under stall");

  // Each queue pop lands in the lookup stage
  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> s1_v_q)
    else $error("popped transaction did not enter lookup stage");

  // A product moving on always produces a result
  a_prod_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && out_rdy |=> out_v_q)
    else $error("product dropped before output register");

endmodule

// File: rtl/odometry_pose_integrator_unit.sv
// Top level of the dead-reckoning pose integrator.
// Each input transaction (distance and heading increment) yields one output
// transaction with the new pose. The front end folds the heading increment
// into the binary-angle heading and derives the quadrant and the quarter-wave
// table index in the accept cycle; a four-entry queue decouples it from the
// back end, which looks up sine and cosine, forms both products and adds them
// with saturation into the 48-bit x and y accumulators. Throughput is one
// transaction per cycle while the output is not stalled, bounded by the heading
// update in the accept cycle; an accepted transaction passes the queue write,
// then the lookup, product and accumulate registers, before output valid rises.
// Output stalls back up through the stages and the queue to in_ready_o.
module odometry_pose_integrator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [opi_pkg::DIST_W-1:0]   delta_dist_i,
  input  logic signed [opi_pkg::DIST_W-1:0]   delta_heading_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [opi_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [opi_pkg::POS_W-1:0]    pos_y_o,
  output logic [opi_pkg::ANGLE_BITS-1:0]      heading_o
);

  logic         q_full, push, pop, q_valid;
  opi_pkg::op_t front_op, back_op;

  opi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .delta_dist_i    (delta_dist_i),
    .delta_heading_i (delta_heading_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .op_o            (front_op)
  );

  opi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (back_op)
  );

  opi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .op_i        (back_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .heading_o   (heading_o)
  );

endmodule
